FILE: design/button_event_history_ring_defines.svh
// Assertion macros for the button event history ring.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef BUTTON_EVENT_HISTORY_RING_DEFINES_SVH
`define BUTTON_EVENT_HISTORY_RING_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define BEHR_ASSERT_NOW(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |-> (effect)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define BEHR_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

FILE: design/behr_pkg.sv
// Shared types, codes and the event encoder for the button event history ring.
// No dependencies.
package behr_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int MAX_OUT       = 48;
	localparam int BTN_COUNT     = 16;
	localparam int HD_W          = 5;
	localparam int OL_W          = 6;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 6;
	localparam int EVT_W         = 17;

	localparam logic [HD_W-1:0] HISTORY_DEPTH_RESET = 5'd16;
	localparam logic [OL_W-1:0] OUT_LIMIT_RESET     = 6'd48;

	localparam logic [CFG_IDX_W-1:0] REG_HISTORY_DEPTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT     = 1'd1;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_INVALID   = 2'd1;
	localparam logic [1:0] STAT_TOO_SMALL = 2'd2;

	localparam logic [7:0] EVT_LEAD = 8'h80;

	localparam logic [7:0] VALUE_CODE [10] = '{
		8'h88, 8'h89, 8'h8a, 8'h8b, 8'h82, 8'h83, 8'h80, 8'h81, 8'h84, 8'h85
	};
	localparam logic [7:0] ON_CODE  [6] = '{8'haf, 8'hb0, 8'hac, 8'had, 8'hb1, 8'hae};
	localparam logic [7:0] OFF_CODE [6] = '{8'h8f, 8'h90, 8'h8c, 8'h8d, 8'h91, 8'h8e};

	typedef struct packed {
		logic       mode;
		logic [4:0] button_index;
		logic [7:0] press_value;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic [1:0] status;
	} out_t;

	// Stored event: bit 16 marks a value byte, 15..8 value, 7..0 code.
	function automatic logic [EVT_W-1:0] encode_event(logic [4:0] btn, logic [7:0] val);
		logic [2:0] tidx;
		logic [7:0] code;
		tidx = 3'(btn - 5'd10);
		code = (val != 8'd0) ? ON_CODE[tidx] : OFF_CODE[tidx];
		if (btn < 5'd10) begin
			return {1'b1, val, VALUE_CODE[4'(btn)]};
		end else begin
			return {1'b0, 8'd0, code};
		end
	endfunction

endpackage

FILE: design/behr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module behr_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/button_event_history_ring.sv
// Top level of the button event history ring: event encoder, ring control, readout.
// Depends on behr_pkg, behr_ram and button_event_history_ring_defines.svh.
//
//   channel | direction | handshake            | word
//   evt     | in        | evt_valid/evt_ready  | behr_pkg::in_t  (mode, button, value)
//   rsp     | out       | rsp_valid/rsp_ready  | behr_pkg::out_t (byte, flags, status)
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One event word at a time. Each word first folds the front pointer into the
// current depth in ST_NORM, one subtraction per step (none unless the depth shrank).
// Push: ST_PUSH waits for the response register to free up, then writes the ring.
// Readout: a length scan of stored events, one ring read each, then for each emitted
// event a ring read and its bytes; the single ring read port serializes this.
// Reset clears pointer, count and registers; ring contents stay undefined.
// A stalled response holds its word; the next word can be taken meanwhile.
`include "button_event_history_ring_defines.svh"

module button_event_history_ring #(
	parameter int DEPTH = behr_pkg::DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            evt_valid,
	output logic                            evt_ready,
	input  behr_pkg::in_t                   evt,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output behr_pkg::out_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [behr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [behr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_NORM     = 3'd1;
	localparam logic [2:0] ST_PUSH     = 3'd2;
	localparam logic [2:0] ST_P1_ISSUE = 3'd3;
	localparam logic [2:0] ST_P1_EVAL  = 3'd4;
	localparam logic [2:0] ST_P2_START = 3'd5;
	localparam logic [2:0] ST_P2_ISSUE = 3'd6;
	localparam logic [2:0] ST_P2_EMIT  = 3'd7;

	// Configuration registers.
	logic [behr_pkg::HD_W-1:0] history_depth_q;
	logic [behr_pkg::OL_W-1:0] out_limit_q;

	// Ring pointer and fill.
	logic [AW-1:0] front_q;
	logic [CW-1:0] entry_count_q;
	// Front pointer folded into the active depth for the word in progress;
	// only a valid push moves front_q itself.
	logic [AW-1:0] base_q;

	// Sequencer.
	logic [2:0]                state_q;
	behr_pkg::in_t             item_q;
	logic [AW-1:0]             slot_q;
	logic [CW-1:0]             idx_q;
	logic [5:0]                n_q;
	logic [5:0]                emit_q;
	logic [1:0]                pos_q;
	logic [1:0]                status_q;

	// Response register.
	logic                      out_valid_q;
	behr_pkg::out_t            out_q;

	// Derived values.
	logic [CW-1:0]             depth_eff;
	logic [5:0]                limit;
	logic [CW-1:0]             walk_cnt;
	logic                      btn_ok;
	logic                      can_load;
	logic                      load_out;
	behr_pkg::out_t            out_next;
	logic [AW-1:0]             new_front;
	logic [CW:0]               cnt_inc;
	logic [AW-1:0]             next_slot;
	logic [6:0]                n_sum;
	logic                      ev_end;
	logic                      is_last;

	logic                      ram_we;
	logic [behr_pkg::EVT_W-1:0] ram_wdata;
	logic [behr_pkg::EVT_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;
	assign evt_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Clamp the configured depth into 1..DEPTH and the limit to MAX_OUT.
	always_comb begin
		if (history_depth_q == '0) begin
			depth_eff = CW'(1);
		end else if (history_depth_q > behr_pkg::HD_W'(DEPTH)) begin
			depth_eff = CW'(DEPTH);
		end else begin
			depth_eff = CW'(history_depth_q);
		end
	end

	assign limit    = (out_limit_q > 6'(behr_pkg::MAX_OUT)) ? 6'(behr_pkg::MAX_OUT)
	                                                        : out_limit_q;
	assign walk_cnt = (entry_count_q < depth_eff) ? entry_count_q : depth_eff;
	assign btn_ok   = (item_q.button_index < 5'(behr_pkg::BTN_COUNT));
	assign can_load = !out_valid_q || rsp_ready;

	// Step the folded front back by one, wrapping at the active depth.
	assign new_front = (base_q == '0) ? AW'(depth_eff - 1'b1) : base_q - 1'b1;
	assign cnt_inc   = (CW+1)'(entry_count_q) + 1'b1;
	assign next_slot = ((CW+1)'(slot_q) + 1'b1 == (CW+1)'(depth_eff)) ? '0 : slot_q + 1'b1;
	assign n_sum     = 7'(n_q) + (ram_rdata[16] ? 7'd3 : 7'd2);
	assign ev_end    = ram_rdata[16] ? (pos_q == 2'd2) : (pos_q == 2'd1);
	assign is_last   = (emit_q + 1'b1 == n_q);
	assign ram_wdata = behr_pkg::encode_event(item_q.button_index, item_q.press_value);

	// Response word and ring write for the current step.
	always_comb begin
		load_out = 1'b0;
		ram_we   = 1'b0;
		out_next = '{out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1, status: status_q};
		unique case (state_q)
			ST_PUSH: begin
				load_out        = can_load;
				ram_we          = can_load && btn_ok;
				out_next.status = btn_ok ? behr_pkg::STAT_OK : behr_pkg::STAT_INVALID;
			end
			ST_P2_START: begin
				load_out = can_load && (n_q == '0);
			end
			ST_P2_EMIT: begin
				load_out            = can_load;
				out_next.byte_valid = 1'b1;
				out_next.last       = is_last;
				case (pos_q)
					2'd0:    out_next.out_byte = behr_pkg::EVT_LEAD;
					2'd1:    out_next.out_byte = ram_rdata[7:0];
					default: out_next.out_byte = ram_rdata[15:8];
				endcase
			end
			default: begin
				load_out = 1'b0;
			end
		endcase
	end

	behr_ram #(
		.WIDTH(behr_pkg::EVT_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(new_front),
		.wdata(ram_wdata),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	// Configuration writes; the user must keep the block idle when these arrive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_depth_q <= behr_pkg::HISTORY_DEPTH_RESET;
			out_limit_q     <= behr_pkg::OUT_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				behr_pkg::REG_HISTORY_DEPTH: history_depth_q <= behr_pkg::HD_W'(cfg_data);
				behr_pkg::REG_OUT_LIMIT:     out_limit_q     <= cfg_data;
				default:                     out_limit_q     <= out_limit_q;
			endcase
		end
	end

	// Response register: drop on handoff, load a new word when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_next;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			front_q       <= '0;
			entry_count_q <= '0;
			base_q        <= '0;
			item_q        <= '0;
			slot_q        <= '0;
			idx_q         <= '0;
			n_q           <= '0;
			emit_q        <= '0;
			pos_q         <= '0;
			status_q      <= behr_pkg::STAT_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (evt_valid) begin
						item_q   <= evt;
						base_q   <= front_q;
						n_q      <= '0;
						idx_q    <= '0;
						status_q <= behr_pkg::STAT_OK;
						state_q  <= ST_NORM;
					end
				end
				ST_NORM: begin
					// Fold the front pointer into the active depth one step at a time.
					if ((CW+1)'(base_q) >= (CW+1)'(depth_eff)) begin
						base_q <= AW'((CW+1)'(base_q) - (CW+1)'(depth_eff));
					end else begin
						slot_q  <= base_q;
						state_q <= item_q.mode ? ST_P1_ISSUE : ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (can_load) begin
						if (btn_ok) begin
							front_q       <= new_front;
							entry_count_q <= (cnt_inc >= (CW+1)'(depth_eff)) ? depth_eff
							                                                  : CW'(cnt_inc);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_P1_ISSUE: begin
					// Ring read of slot_q is under way.
					state_q <= (idx_q == walk_cnt) ? ST_P2_START : ST_P1_EVAL;
				end
				ST_P1_EVAL: begin
					if (n_sum > 7'(limit)) begin
						status_q <= behr_pkg::STAT_TOO_SMALL;
						state_q  <= ST_P2_START;
					end else begin
						n_q     <= 6'(n_sum);
						idx_q   <= idx_q + 1'b1;
						slot_q  <= next_slot;
						state_q <= ST_P1_ISSUE;
					end
				end
				ST_P2_START: begin
					if (n_q == '0) begin
						if (can_load) begin
							state_q <= ST_IDLE;
						end
					end else begin
						slot_q  <= base_q;
						emit_q  <= '0;
						state_q <= ST_P2_ISSUE;
					end
				end
				ST_P2_ISSUE: begin
					pos_q   <= '0;
					state_q <= ST_P2_EMIT;
				end
				ST_P2_EMIT: begin
					if (can_load) begin
						emit_q <= emit_q + 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end else if (ev_end) begin
							slot_q  <= next_slot;
							state_q <= ST_P2_ISSUE;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BEHR_ASSERT_NOW(a_front_folded,
		(state_q != ST_IDLE && state_q != ST_NORM),
		((CW+1)'(base_q) < (CW+1)'(depth_eff)),
		"front pointer outside active depth")
	`BEHR_ASSERT_NOW(a_emit_in_range, (state_q == ST_P2_EMIT), (emit_q < n_q),
		"readout emits beyond scanned length")
	`BEHR_ASSERT_NOW(a_len_fits, (state_q != ST_IDLE), (n_q <= limit),
		"scanned length exceeds output limit")
	`BEHR_ASSERT_NEXT(a_push_counts, ram_we, (entry_count_q != '0 && state_q == ST_IDLE),
		"push left the ring empty")

endmodule
